/* src/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types and constants of the block buffer cache
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned DefNumSlots = 32;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned DevW    = 8;
  localparam int unsigned BlkW    = 32;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned CountW  = 8;
  localparam int unsigned StatusW = 2;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  localparam logic [ReqW-1:0] ReqLookup     = 3'd0;
  localparam logic [ReqW-1:0] ReqFillDone   = 3'd1;
  localparam logic [ReqW-1:0] ReqFillFailed = 3'd2;
  localparam logic [ReqW-1:0] ReqRelease    = 3'd3;
  localparam logic [ReqW-1:0] ReqPin        = 3'd4;
  localparam logic [ReqW-1:0] ReqUnpin      = 3'd5;
  localparam logic [ReqW-1:0] ReqWbDone     = 3'd6;
  localparam logic [ReqW-1:0] ReqMarkDirty  = 3'd7;

  localparam logic [StatusW-1:0] StOk        = 2'd0;
  localparam logic [StatusW-1:0] StNoFree    = 2'd1;
  localparam logic [StatusW-1:0] StUnderflow = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request
    logic search;  // register tag and free search results
    logic apply;   // update state, form result
  } bbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;
  } bbc_stat_t;

endpackage

/* src/bbc_ctrl.sv */
// ----------------------------------------------------------------------------
// bbc_ctrl
// request sequencer: load, search, apply, present result
// ----------------------------------------------------------------------------
module bbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bbc_pkg::bbc_cmd_t cmd_o
);
  import bbc_pkg::*;

  typedef enum logic [1:0] {SIdle, SSearch, SApply, SOut} state_e;
  state_e state_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == SIdle) && in_valid_i;
    cmd_o.search = (state_q == SSearch);
    cmd_o.apply  = (state_q == SApply);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      case (state_q)
        SIdle:   if (in_valid_i) state_q <= SSearch;
        SSearch: state_q <= SApply;
        SApply:  state_q <= SOut;
        SOut:    if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

/* src/bbc_datapath.sv */
// ----------------------------------------------------------------------------
// bbc_datapath
// slot state, tag compare, free search, recency list and result register
// ----------------------------------------------------------------------------
module bbc_datapath #(
  parameter int unsigned NumSlots = bbc_pkg::DefNumSlots
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bbc_pkg::bbc_cmd_t              cmd_i,
  output bbc_pkg::bbc_stat_t             stat_o,
  input  logic [bbc_pkg::ReqW-1:0]       req_type_i,
  input  logic [bbc_pkg::DevW-1:0]       device_id_i,
  input  logic [bbc_pkg::BlkW-1:0]       block_number_i,
  input  logic [bbc_pkg::SlotW-1:0]      slot_index_i,
  output logic [bbc_pkg::SlotW-1:0]      result_slot_o,
  output logic                           hit_o,
  output logic                           need_fill_o,
  output logic                           evict_writeback_o,
  output logic [bbc_pkg::BlkW-1:0]       writeback_block_o,
  output logic [bbc_pkg::StatusW-1:0]    status_o
);
  import bbc_pkg::*;

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned PosW = IdxW;

  logic [DevW-1:0]   tag_dev_q [NumSlots];
  logic [BlkW-1:0]   tag_blk_q [NumSlots];
  logic [CountW-1:0] cnt_q     [NumSlots];
  logic [NumSlots-1:0] valid_q, dirty_q;
  // position in recency order of each slot, 0 = front
  logic [PosW-1:0]   pos_q     [NumSlots];

  logic [ReqW-1:0]  req_q;
  logic [DevW-1:0]  dev_q;
  logic [BlkW-1:0]  blk_q;
  logic [SlotW-1:0] sidx_q;

  assign stat_o.is_lookup = (req_q == ReqLookup);

  // search: match with smallest position, free slot with largest position
  logic [NumSlots-1:0] match_vec, free_vec;
  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      match_vec[i] = (tag_dev_q[i] == dev_q) && (tag_blk_q[i] == blk_q);
      free_vec[i]  = (cnt_q[i] == '0);
    end
  end

  // recency positions are a permutation, so a one-hot pick by position works
  logic [NumSlots-1:0] match_pick, free_pick;
  always_comb begin
    match_pick = '0;
    free_pick  = '0;
    for (int i = 0; i < NumSlots; i++) begin
      logic mbest, fbest;
      mbest = match_vec[i];
      fbest = free_vec[i];
      for (int j = 0; j < NumSlots; j++) begin
        if (match_vec[j] && pos_q[j] < pos_q[i]) mbest = 1'b0;
        if (free_vec[j] && pos_q[j] > pos_q[i]) fbest = 1'b0;
      end
      match_pick[i] = mbest;
      free_pick[i]  = fbest;
    end
  end

  logic [IdxW-1:0] match_enc, free_enc;
  always_comb begin
    match_enc = '0;
    free_enc  = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (match_pick[i]) match_enc = IdxW'(i);
      if (free_pick[i])  free_enc  = IdxW'(i);
    end
  end

  logic            hit_q, free_q;
  logic [IdxW-1:0] hsel_q, fsel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      dev_q  <= device_id_i;
      blk_q  <= block_number_i;
      sidx_q <= slot_index_i;
    end
    if (cmd_i.search) begin
      hit_q  <= |match_vec;
      free_q <= |free_vec;
      hsel_q <= match_enc;
      fsel_q <= free_enc;
    end
  end

  // apply stage
  logic            in_pool;
  logic [IdxW-1:0] nidx;
  assign in_pool = (32'(sidx_q) < NumSlots);
  assign nidx    = IdxW'(sidx_q);

  logic [CountW-1:0] ncnt;
  assign ncnt = cnt_q[nidx];

  logic            mv_en;
  logic [IdxW-1:0] mv_slot;
  always_comb begin
    mv_en   = 1'b0;
    mv_slot = fsel_q;
    if (cmd_i.apply) begin
      if (req_q == ReqLookup) begin
        mv_en = !hit_q && free_q;
      end else if (req_q == ReqRelease && in_pool && ncnt == CountW'(1)) begin
        mv_en   = 1'b1;
        mv_slot = nidx;
      end
    end
  end

  logic [PosW-1:0] mv_pos;
  assign mv_pos = pos_q[mv_slot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        tag_dev_q[i] <= '0;
        tag_blk_q[i] <= '0;
        cnt_q[i]     <= '0;
        pos_q[i]     <= PosW'(NumSlots - 1 - i);
      end
      valid_q <= '0;
      dirty_q <= '0;
    end else begin
      if (mv_en) begin
        for (int i = 0; i < NumSlots; i++) begin
          if (IdxW'(i) == mv_slot)   pos_q[i] <= '0;
          else if (pos_q[i] < mv_pos) pos_q[i] <= pos_q[i] + 1'b1;
        end
      end
      if (cmd_i.apply) begin
        if (req_q == ReqLookup) begin
          if (hit_q) begin
            if (cnt_q[hsel_q] != '1) cnt_q[hsel_q] <= cnt_q[hsel_q] + 1'b1;
          end else if (free_q) begin
            tag_dev_q[fsel_q] <= dev_q;
            tag_blk_q[fsel_q] <= blk_q;
            valid_q[fsel_q]   <= 1'b0;
            dirty_q[fsel_q]   <= 1'b0;
            cnt_q[fsel_q]     <= CountW'(1);
          end
        end else if (in_pool) begin
          case (req_q)
            ReqFillDone: valid_q[nidx] <= 1'b1;
            ReqFillFailed, ReqUnpin, ReqRelease:
              if (ncnt != '0) cnt_q[nidx] <= ncnt - 1'b1;
            ReqPin:      if (ncnt != '1) cnt_q[nidx] <= ncnt + 1'b1;
            ReqWbDone:   dirty_q[nidx] <= 1'b0;
            default:     dirty_q[nidx] <= 1'b1;
          endcase
        end
      end
    end
  end

  // result register
  logic [SlotW-1:0]   rsp_slot_d, rsp_slot_q;
  logic               rsp_hit_d, rsp_hit_q;
  logic               rsp_fill_d, rsp_fill_q;
  logic               rsp_evict_d, rsp_evict_q;
  logic [BlkW-1:0]    rsp_wb_d, rsp_wb_q;
  logic [StatusW-1:0] rsp_status_d, rsp_status_q;

  always_comb begin
    rsp_slot_d   = sidx_q;
    rsp_hit_d    = 1'b0;
    rsp_fill_d   = 1'b0;
    rsp_evict_d  = 1'b0;
    rsp_wb_d     = '0;
    rsp_status_d = StOk;
    if (req_q == ReqLookup) begin
      if (hit_q) begin
        rsp_slot_d = SlotW'(hsel_q);
        rsp_hit_d  = 1'b1;
        rsp_fill_d = !valid_q[hsel_q];
      end else if (free_q) begin
        rsp_slot_d  = SlotW'(fsel_q);
        rsp_fill_d  = 1'b1;
        rsp_evict_d = dirty_q[fsel_q];
        rsp_wb_d    = dirty_q[fsel_q] ? tag_blk_q[fsel_q] : '0;
      end else begin
        rsp_slot_d   = '0;
        rsp_status_d = StNoFree;
      end
    end else if (in_pool && ncnt == '0 &&
                 (req_q == ReqFillFailed || req_q == ReqUnpin ||
                  req_q == ReqRelease)) begin
      rsp_status_d = StUnderflow;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      rsp_slot_q   <= rsp_slot_d;
      rsp_hit_q    <= rsp_hit_d;
      rsp_fill_q   <= rsp_fill_d;
      rsp_evict_q  <= rsp_evict_d;
      rsp_wb_q     <= rsp_wb_d;
      rsp_status_q <= rsp_status_d;
    end
  end

  assign result_slot_o     = rsp_slot_q;
  assign hit_o             = rsp_hit_q;
  assign need_fill_o       = rsp_fill_q;
  assign evict_writeback_o = rsp_evict_q;
  assign writeback_block_o = rsp_wb_q;
  assign status_o          = rsp_status_q;
endmodule

/* src/block_buffer_cache_lru_core.sv */
// sequence: after the input transfer the request passes the search and apply states,
//   and the registered result is then offered on the output
// ordering: a new request is taken only after the result of the last one has been taken;
//   set by the controller sequence over the shared compare and search logic
// reset: asynchronous active low; tags, counts and marks clear, recency order
//   holds the highest slot at the front and slot zero at the tail
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_core
// lru buffer cache of tagged slots with reference counts
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_core #(
  parameter int unsigned NumSlots = bbc_pkg::DefNumSlots
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // req_type[2:0]
  input  logic [bbc_pkg::ReqW-1:0]       s_axis_tuser,
  // device_id[7:0], block_number[39:8], slot_index[44:40], zero[47:45]
  input  logic [bbc_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_slot[4:0], hit[5], need_fill[6], evict_writeback[7],
  // writeback_block[39:8], status[41:40], zero[47:42]
  output logic [bbc_pkg::OutDataW-1:0]   m_axis_tdata
);
  import bbc_pkg::*;

  bbc_cmd_t  cmd;
  bbc_stat_t stat;

  logic [SlotW-1:0]   r_slot;
  logic               r_hit, r_fill, r_evict;
  logic [BlkW-1:0]    r_wb;
  logic [StatusW-1:0] r_status;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bbc_datapath #(.NumSlots(NumSlots)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (s_axis_tuser),
    .device_id_i       (s_axis_tdata[7:0]),
    .block_number_i    (s_axis_tdata[39:8]),
    .slot_index_i      (s_axis_tdata[44:40]),
    .result_slot_o     (r_slot),
    .hit_o             (r_hit),
    .need_fill_o       (r_fill),
    .evict_writeback_o (r_evict),
    .writeback_block_o (r_wb),
    .status_o          (r_status)
  );

  assign m_axis_tdata = {6'd0, r_status, r_wb, r_evict, r_fill, r_hit, r_slot};

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output phases overlap");

  a_out_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.apply))
    else $error("result without apply step");

  a_hit_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> stat.is_lookup)
    else $error("hit reported for non-lookup");
endmodule

/* tb/tb_block_buffer_cache_lru_core.sv */
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru_core
// self-checking bench for the lru block buffer cache: a directed table of
// requests, then random request sequences, every result compared against the typed
// row or else against a software copy of the slot pool kept alongside the block
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int unsigned Slots = DefNumSlots;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [BlkW-1:0]    wb_block;
    logic               evict_wb;
    logic               need_fill;
    logic               hit;
    logic [SlotW-1:0]   slot;
  } cache_rsp_t;

  typedef struct {
    logic [ReqW-1:0]  req;
    logic [DevW-1:0]  dev;
    logic [BlkW-1:0]  blk;
    logic [SlotW-1:0] slot;
    bit               typed;
    cache_rsp_t       rsp;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // req_type
  logic [ReqW-1:0]     s_axis_tuser = '0;
  // device_id, block_number, slot_index
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // result_slot, hit, need_fill, evict_writeback, writeback_block, status
  logic [OutDataW-1:0] m_axis_tdata;

  block_buffer_cache_lru_core #(.NumSlots(Slots)) DUT (.*);

  // shadow copy of the slot pool
  logic [DevW-1:0]   pool_dev   [Slots];
  logic [BlkW-1:0]   pool_blk   [Slots];
  logic [CountW-1:0] pool_cnt   [Slots];
  logic              pool_valid [Slots];
  logic              pool_dirty [Slots];
  logic [SlotW-1:0]  lru_list   [Slots];

  cache_rsp_t pending_rsp[$];
  int unsigned n_mismatch = 0, n_rsp = 0, n_hit = 0, n_evict = 0, n_nofree = 0, n_uflow = 0;
  bit stim_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void pool_reset();
    for (int i = 0; i < Slots; i++) begin
      pool_dev[i] = '0; pool_blk[i] = '0; pool_cnt[i] = '0;
      pool_valid[i] = 1'b0; pool_dirty[i] = 1'b0;
      lru_list[i] = SlotW'(Slots - 1 - i);
    end
  endfunction

  function automatic void move_to_front(int unsigned s);
    int p;
    p = 0;
    while (p < Slots && lru_list[p] != s) p++;
    for (; p > 0; p--) lru_list[p] = lru_list[p-1];
    lru_list[0] = SlotW'(s);
  endfunction

  function automatic cache_rsp_t cache_access(logic [ReqW-1:0] req, logic [DevW-1:0] dev,
                                              logic [BlkW-1:0] blk, logic [SlotW-1:0] slot);
    cache_rsp_t r;
    bit found;
    int unsigned s;
    r = '0;
    r.slot = slot;
    r.status = StOk;
    found = 1'b0;
    if (req == ReqLookup) begin
      for (int i = 0; i < Slots && !found; i++) begin
        s = lru_list[i];
        if (pool_dev[s] == dev && pool_blk[s] == blk) begin
          if (pool_cnt[s] != 8'hff) pool_cnt[s]++;
          r.slot = SlotW'(s); r.hit = 1'b1; r.need_fill = !pool_valid[s];
          found = 1'b1;
        end
      end
      for (int i = Slots - 1; i >= 0 && !found; i--) begin
        s = lru_list[i];
        if (pool_cnt[s] == 0) begin
          if (pool_dirty[s]) begin
            r.evict_wb = 1'b1; r.wb_block = pool_blk[s];
          end
          pool_dev[s] = dev; pool_blk[s] = blk; pool_valid[s] = 1'b0;
          pool_dirty[s] = 1'b0; pool_cnt[s] = CountW'(1);
          move_to_front(s);
          r.slot = SlotW'(s); r.need_fill = 1'b1;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.slot = '0; r.status = StNoFree;
      end
    end else if (slot < Slots) begin
      case (req)
        ReqFillDone: pool_valid[slot] = 1'b1;
        ReqFillFailed, ReqUnpin: begin
          if (pool_cnt[slot] == 0) r.status = StUnderflow;
          else pool_cnt[slot]--;
        end
        ReqRelease: begin
          if (pool_cnt[slot] == 0) r.status = StUnderflow;
          else begin
            pool_cnt[slot]--;
            if (pool_cnt[slot] == 0) move_to_front(slot);
          end
        end
        ReqPin: if (pool_cnt[slot] != 8'hff) pool_cnt[slot]++;
        ReqWbDone: pool_dirty[slot] = 1'b0;
        default: pool_dirty[slot] = 1'b1;
      endcase
    end
    return r;
  endfunction

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_req(logic [ReqW-1:0] req, logic [DevW-1:0] dev, logic [BlkW-1:0] blk,
                          logic [SlotW-1:0] slot, bit typed, cache_rsp_t typed_rsp);
    cache_rsp_t pred;
    pred = cache_access(req, dev, blk, slot);
    if (typed && pred != typed_rsp)
      $display("table row disagrees with prediction: req %0d row %h pred %h",
               req, typed_rsp, pred);
    pending_rsp.push_back(typed ? typed_rsp : pred);
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, slot, blk, dev};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    // the block takes no new request after a transfer until its result is taken anyway
    @(posedge clk_i);
  endtask

  // result side: random stalls, compare against oldest expectation
  initial begin
    cache_rsp_t got, want;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = cache_rsp_t'(m_axis_tdata[41:0]);
        n_rsp++;
        if (pending_rsp.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected transfer %h", m_axis_tdata);
        end else begin
          want = pending_rsp.pop_front();
          if (got.status == StNoFree) n_nofree++;
          if (got.status == StUnderflow) n_uflow++;
          if (got.hit) n_hit++;
          if (got.evict_wb) n_evict++;
          if (got != want || m_axis_tdata[47:42] != '0) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch: exp slot %0d hit %b fill %b ev %b wb %h st %0d",
                       want.slot, want.hit, want.need_fill, want.evict_wb, want.wb_block,
                       want.status);
              $display("          act slot %0d hit %b fill %b ev %b wb %h st %0d pad %h",
                       got.slot, got.hit, got.need_fill, got.evict_wb, got.wb_block,
                       got.status, m_axis_tdata[47:42]);
            end
          end
        end
      end
      if (stim_done && $urandom_range(0, 1)) m_axis_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) m_axis_tready <= ~m_axis_tready;
      else m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t dir_tbl[$];
    dir_row_t row;
    logic [ReqW-1:0] req;
    logic [DevW-1:0] dev;
    logic [BlkW-1:0] blk;
    logic [SlotW-1:0] slot;
    logic [DevW-1:0] hot_dev[4];
    logic [BlkW-1:0] hot_blk[4];
    int unsigned k;

    pool_reset();
    // device 0 block 0 hits slot 31 after reset, not valid
    dir_tbl.push_back('{ReqLookup, 8'h00, 32'h0, 5'd0, 1, '{StOk, 32'h0, 1'b0, 1'b1, 1'b1, 5'd31}});
    // extreme tags miss, take tail slots 0 and 1
    dir_tbl.push_back('{ReqLookup, 8'hff, 32'hffff_ffff, 5'd31, 1,
                        '{StOk, 32'h0, 1'b0, 1'b1, 1'b0, 5'd0}});
    dir_tbl.push_back('{ReqLookup, 8'h5a, 32'ha5a5_5a5a, 5'd0, 1,
                        '{StOk, 32'h0, 1'b0, 1'b1, 1'b0, 5'd1}});
    dir_tbl.push_back('{ReqFillDone, 8'hff, 32'hffff_ffff, 5'd0, 0, '0});
    dir_tbl.push_back('{ReqLookup, 8'hff, 32'hffff_ffff, 5'd0, 0, '0});
    dir_tbl.push_back('{ReqMarkDirty, 8'h00, 32'h0, 5'd0, 1, '{StOk, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0}});
    dir_tbl.push_back('{ReqRelease, 8'h00, 32'h0, 5'd0, 0, '0});
    dir_tbl.push_back('{ReqRelease, 8'h00, 32'h0, 5'd0, 0, '0});
    // underflow on a zero count
    dir_tbl.push_back('{ReqRelease, 8'h00, 32'h0, 5'd5, 1,
                        '{StUnderflow, 32'h0, 1'b0, 1'b0, 1'b0, 5'd5}});
    dir_tbl.push_back('{ReqUnpin, 8'h00, 32'h0, 5'd6, 1, '{StUnderflow, 32'h0, 1'b0, 1'b0, 1'b0, 5'd6}});
    dir_tbl.push_back('{ReqFillFailed, 8'h00, 32'h0, 5'd7, 1,
                        '{StUnderflow, 32'h0, 1'b0, 1'b0, 1'b0, 5'd7}});
    dir_tbl.push_back('{ReqPin, 8'h00, 32'h0, 5'd31, 0, '0});
    dir_tbl.push_back('{ReqUnpin, 8'h00, 32'h0, 5'd31, 0, '0});
    dir_tbl.push_back('{ReqFillFailed, 8'h00, 32'h0, 5'd31, 0, '0});
    dir_tbl.push_back('{ReqWbDone, 8'h00, 32'h0, 5'd0, 0, '0});
    dir_tbl.push_back('{ReqMarkDirty, 8'h00, 32'h0, 5'd1, 0, '0});
    dir_tbl.push_back('{ReqRelease, 8'h00, 32'h0, 5'd1, 0, '0});
    // six lookups of new tags, each a miss that takes a free slot from the tail
    for (int i = 0; i < 6; i++)
      dir_tbl.push_back('{ReqLookup, 8'h11, 32'h1000 + i, 5'd0, 0, '0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      send_req(row.req, row.dev, row.blk, row.slot, row.typed, row.rsp);
      idle_gap();
    end

    // pin everything until no free buffer, then one more lookup
    for (int i = 0; i < Slots; i++) send_req(ReqPin, '0, '0, SlotW'(i), 0, '0);
    send_req(ReqLookup, 8'h77, 32'h7777_7777, 5'd3, 1,
             '{StNoFree, 32'h0, 1'b0, 1'b0, 1'b0, 5'd0});
    // saturate a count at the top, the slot stays pinned afterwards
    for (int i = 0; i < 256; i++) send_req(ReqPin, '0, '0, 5'd9, 0, '0);
    for (int i = 0; i < Slots; i++) send_req(ReqUnpin, '0, '0, SlotW'(i), 0, '0);

    // sender holds off until the result side has drained
    while (pending_rsp.size() != 0) @(posedge clk_i);

    for (int i = 0; i < 4; i++) begin
      hot_dev[i] = DevW'($urandom_range(0, 3));
      hot_blk[i] = $urandom_range(0, 15);
    end
    // random part: mostly lookup / fill / dirty / release sequences
    k = 0;
    while (k < 160) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 2) == 0) begin
          dev = hot_dev[$urandom_range(0, 3)]; blk = hot_blk[$urandom_range(0, 3)];
        end else begin
          dev = DevW'($urandom_range(0, 3)); blk = $urandom_range(0, 63);
          if ($urandom_range(0, 9) == 0) begin
            dev = DevW'($urandom); blk = $urandom;
          end
        end
        send_req(ReqLookup, dev, blk, SlotW'($urandom), 0, '0);
        slot = pending_rsp.size() ? pending_rsp[$].slot : 5'd0;
        send_req($urandom_range(0, 3) ? ReqFillDone : ReqFillFailed, DevW'($urandom),
                 $urandom, slot, 0, '0);
        if ($urandom_range(0, 1))
          send_req(ReqMarkDirty, DevW'($urandom), $urandom, slot, 0, '0);
        if ($urandom_range(0, 4) == 0)
          send_req(ReqWbDone, DevW'($urandom), $urandom, slot, 0, '0);
        if ($urandom_range(0, 6) != 0)
          send_req(ReqRelease, DevW'($urandom), $urandom, slot, 0, '0);
        k += 4;
      end else begin
        req = ReqW'($urandom); slot = SlotW'($urandom);
        send_req(req, DevW'($urandom), $urandom, slot, 0, '0);
        k++;
      end
      idle_gap();
    end

    stim_done = 1'b1;
    k = 0;
    while (pending_rsp.size() != 0 && k < 100000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (20) @(posedge clk_i);
    $display("ran %0d results: %0d hits, %0d dirty evictions, %0d no-free, %0d underflows",
             n_rsp, n_hit, n_evict, n_nofree, n_uflow);
    if (n_mismatch == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, pending_rsp.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
